### design/coinchg_pkg.sv
// coinchg_pkg: shared types, constants and microcode for the coin changer
// holds item structs, status/command codes, denomination tables, control store
// no dependencies
`default_nettype none

package coinchg_pkg;

   // denomination store geometry
   localparam int NUM_DENOMS  = 8;
   localparam int DENOM_IDX_W = 3;

   // command codes of an input item
   typedef enum logic [2:0] {
      CMD_START  = 3'd0,
      CMD_INSERT = 3'd1,
      CMD_CANCEL = 3'd2,
      CMD_FILL   = 3'd3,
      CMD_LOAD   = 3'd4,
      CMD_READ   = 3'd5
   } cmd_type;

   // status codes of a result item
   typedef enum logic [2:0] {
      ST_ACCEPTED  = 3'd0,
      ST_DISPENSED = 3'd1,
      ST_NO_CHANGE = 3'd2,
      ST_BAD_COIN  = 3'd3,
      ST_BAD_ITEM  = 3'd4,
      ST_CANCELLED = 3'd5,
      ST_IDLE      = 3'd6,
      ST_ADMIN     = 3'd7
   } status_type;

   // input item
   typedef struct packed {
      logic [2:0]  command;
      logic [15:0] price_cents;
      logic        in_stock;
      logic [15:0] coin_cents;
      logic [2:0]  denom_index;
      logic [15:0] count_value;
   } req_type;

   // result item
   typedef struct packed {
      status_type  status;
      logic        dispense;
      logic [15:0] amount_due;
      logic [9:0]  change_cents;
      logic [15:0] count_ten_dollar;
      logic [15:0] count_five_dollar;
      logic [15:0] count_two_dollar;
      logic [15:0] count_one_dollar;
      logic [15:0] count_fifty_cent;
      logic [15:0] count_twenty_cent;
      logic [15:0] count_ten_cent;
      logic [15:0] count_five_cent;
   } rsp_type;

   // datapath operations selected by the control word
   typedef enum logic [3:0] {
      UOP_NONE,
      UOP_START,
      UOP_COIN,
      UOP_DIV,
      UOP_TAKE,
      UOP_SETTLE,
      UOP_CANCEL,
      UOP_FILL,
      UOP_LOAD,
      UOP_READ,
      UOP_UNUSED,
      UOP_RESP
   } uop_type;

   // sequencing of the step counter
   typedef enum logic [2:0] {
      COND_NEXT,
      COND_JUMP,
      COND_COIN_END,
      COND_MORE,
      COND_END
   } cond_type;

   typedef logic [3:0] upc_type;

   typedef struct packed {
      uop_type  op;
      cond_type cond;
      upc_type  target;
   } ucode_type;

   // datapath flags tested by conditional jumps
   typedef struct packed {
      logic coin_end;
      logic more;
   } flags_type;

   typedef struct packed {
      logic                   ok;
      logic [DENOM_IDX_W-1:0] idx;
   } coin_hit_type;

   // control store addresses
   localparam upc_type A_START  = 4'd0;
   localparam upc_type A_COIN   = 4'd1;
   localparam upc_type A_DIV    = 4'd2;
   localparam upc_type A_TAKE   = 4'd3;
   localparam upc_type A_SETTLE = 4'd4;
   localparam upc_type A_CANCEL = 4'd5;
   localparam upc_type A_FILL   = 4'd6;
   localparam upc_type A_LOAD   = 4'd7;
   localparam upc_type A_READ   = 4'd8;
   localparam upc_type A_UNUSED = 4'd9;
   localparam upc_type A_RESP   = 4'd10;

   // coin value in cents, largest first
   function automatic logic [9:0] denom_cents(input logic [DENOM_IDX_W-1:0] idx);
      logic [9:0] v;
      unique case (idx)
         3'd0:    v = 10'd1000;
         3'd1:    v = 10'd500;
         3'd2:    v = 10'd200;
         3'd3:    v = 10'd100;
         3'd4:    v = 10'd50;
         3'd5:    v = 10'd20;
         3'd6:    v = 10'd10;
         default: v = 10'd5;
      endcase
      return v;
   endfunction

   // floor(2^16 / coin value), quotient estimate is low by at most one
   function automatic logic [13:0] denom_recip(input logic [DENOM_IDX_W-1:0] idx);
      logic [13:0] v;
      unique case (idx)
         3'd0:    v = 14'd65;
         3'd1:    v = 14'd131;
         3'd2:    v = 14'd327;
         3'd3:    v = 14'd655;
         3'd4:    v = 14'd1310;
         3'd5:    v = 14'd3276;
         3'd6:    v = 14'd6553;
         default: v = 14'd13107;
      endcase
      return v;
   endfunction

   // match an inserted value against the denominations
   function automatic coin_hit_type denom_lookup(input logic [15:0] cents);
      coin_hit_type hit;
      hit.ok  = 1'b0;
      hit.idx = '0;
      for (int i = 0; i < NUM_DENOMS; i++) begin
         if (cents == {6'd0, denom_cents(DENOM_IDX_W'(i))}) begin
            hit.ok  = 1'b1;
            hit.idx = DENOM_IDX_W'(i);
         end
      end
      return hit;
   endfunction

   // entry point of each command's routine
   function automatic upc_type dispatch(input logic [2:0] command);
      upc_type a;
      unique case (command)
         CMD_START:  a = A_START;
         CMD_INSERT: a = A_COIN;
         CMD_CANCEL: a = A_CANCEL;
         CMD_FILL:   a = A_FILL;
         CMD_LOAD:   a = A_LOAD;
         CMD_READ:   a = A_READ;
         default:    a = A_UNUSED;
      endcase
      return a;
   endfunction

   // control store
   function automatic ucode_type ucode_rom(input upc_type pc);
      ucode_type w;
      unique case (pc)
         A_START:  w = '{op: UOP_START,  cond: COND_JUMP,     target: A_RESP};
         A_COIN:   w = '{op: UOP_COIN,   cond: COND_COIN_END, target: A_RESP};
         A_DIV:    w = '{op: UOP_DIV,    cond: COND_NEXT,     target: A_DIV};
         A_TAKE:   w = '{op: UOP_TAKE,   cond: COND_MORE,     target: A_DIV};
         A_SETTLE: w = '{op: UOP_SETTLE, cond: COND_JUMP,     target: A_RESP};
         A_CANCEL: w = '{op: UOP_CANCEL, cond: COND_JUMP,     target: A_RESP};
         A_FILL:   w = '{op: UOP_FILL,   cond: COND_JUMP,     target: A_RESP};
         A_LOAD:   w = '{op: UOP_LOAD,   cond: COND_JUMP,     target: A_RESP};
         A_READ:   w = '{op: UOP_READ,   cond: COND_JUMP,     target: A_RESP};
         A_UNUSED: w = '{op: UOP_UNUSED, cond: COND_JUMP,     target: A_RESP};
         default:  w = '{op: UOP_RESP,   cond: COND_END,      target: A_RESP};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

### design/coinchg_useq.sv
// coinchg_useq: microcode sequencer with step counter and conditional jumps
// depends on coinchg_pkg for the control store and dispatch table
`default_nettype none

module coinchg_useq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  go,
   input  wire logic [2:0]            command,
   input  wire coinchg_pkg::flags_type flags,
   output coinchg_pkg::uop_type       op,
   output logic                       busy
);
   import coinchg_pkg::*;

   logic      running_ff, running_in;
   upc_type   pc_ff, pc_in;
   ucode_type word;

   assign word = ucode_rom(pc_ff);

   // step counter and jumps
   always_comb begin
      running_in = running_ff;
      pc_in      = pc_ff;
      if (!running_ff) begin
         if (go) begin
            running_in = 1'b1;
            pc_in      = dispatch(command);
         end
      end else begin
         unique case (word.cond)
            COND_NEXT:     pc_in = pc_ff + 4'd1;
            COND_JUMP:     pc_in = word.target;
            COND_COIN_END: pc_in = flags.coin_end ? word.target : pc_ff + 4'd1;
            COND_MORE:     pc_in = flags.more ? word.target : pc_ff + 4'd1;
            default:       running_in = 1'b0;
         endcase
      end
   end

   // control word to the datapath
   always_comb begin
      op   = running_ff ? word.op : UOP_NONE;
      busy = running_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         pc_ff      <= A_RESP;
      end else begin
         running_ff <= running_in;
         pc_ff      <= pc_in;
      end
   end

endmodule

`default_nettype wire

### design/coinchg_dpath.sv
// coinchg_dpath: session registers, coin store and greedy change datapath
// depends on coinchg_pkg; driven one operation per cycle by coinchg_useq
`default_nettype none

module coinchg_dpath #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   go,
   input  wire coinchg_pkg::req_type   req_item,
   input  wire coinchg_pkg::uop_type   op,
   input  wire logic                   csr_we,
   input  wire logic [15:0]            csr_data,
   output coinchg_pkg::flags_type      flags,
   output logic                        rsp_valid,
   output coinchg_pkg::rsp_type        rsp_item
);
   import coinchg_pkg::*;

   localparam int XW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   typedef logic [COUNT_BITS-1:0] cnt_type;

   req_type       req_ff;
   logic [15:0]   default_ff, default_in;
   logic          active_ff, active_in;
   logic [15:0]   price_ff, price_in;
   logic [16:0]   paid_ff, paid_in;
   cnt_type       committed_ff [NUM_DENOMS];
   cnt_type       committed_in [NUM_DENOMS];
   cnt_type       working_ff [NUM_DENOMS];
   cnt_type       working_in [NUM_DENOMS];
   logic [7:0]    given_ff [NUM_DENOMS];
   logic [7:0]    given_in [NUM_DENOMS];
   logic [9:0]    left_ff, left_in;
   logic [9:0]    change_ff, change_in;
   logic [2:0]    idx_ff, idx_in;
   logic [7:0]    q_ff, q_in;
   status_type    status_ff, status_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   coin_hit_type  hit;
   logic [16:0]   paid_next;
   logic [2:0]    rd_idx;
   cnt_type       rd_cnt;
   logic [9:0]    coin_val;
   logic [23:0]   recip_prod;
   logic [17:0]   qd_prod;
   logic [17:0]   cd_prod;
   logic [9:0]    rem0;
   logic [7:0]    q_fix;
   logic [9:0]    rem_fix;
   logic          short;
   logic [7:0]    take;
   logic [15:0]   out_cnt [NUM_DENOMS];

   // low 16 bits of a count, zero-extended when counts are narrower
   function automatic logic [15:0] low16(input cnt_type v);
      logic [XW-1:0] w;
      w = XW'(v);
      return w[15:0];
   endfunction

   // coin decode, shared read port of the working counts
   always_comb begin
      hit       = denom_lookup(req_ff.coin_cents);
      rd_idx    = (op == UOP_COIN) ? hit.idx : idx_ff;
      rd_cnt    = working_ff[rd_idx];
      paid_next = paid_ff + {7'd0, denom_cents(hit.idx)};
      coin_val  = denom_cents(idx_ff);
   end

   // flags for the sequencer
   always_comb begin
      flags.coin_end = !active_ff || !hit.ok || (paid_next < {1'b0, price_ff});
      flags.more     = (idx_ff != 3'd7);
   end

   // one greedy step: quotient estimate, correction, limit by coins held
   always_comb begin
      recip_prod = 24'(left_ff) * 24'(denom_recip(idx_ff));
      qd_prod    = 18'(q_ff) * 18'(coin_val);
      rem0       = left_ff - qd_prod[9:0];
      if (rem0 >= coin_val) begin
         q_fix   = q_ff + 8'd1;
         rem_fix = rem0 - coin_val;
      end else begin
         q_fix   = q_ff;
         rem_fix = rem0;
      end
      short   = rd_cnt < COUNT_BITS'(q_fix);
      cd_prod = 18'(rd_cnt[7:0]) * 18'(coin_val);
      take    = short ? rd_cnt[7:0] : q_fix;
   end

   // operation decode
   always_comb begin
      default_in   = csr_we ? csr_data : default_ff;
      active_in    = active_ff;
      price_in     = price_ff;
      paid_in      = paid_ff;
      committed_in = committed_ff;
      working_in   = working_ff;
      given_in     = given_ff;
      left_in      = left_ff;
      change_in    = change_ff;
      idx_in       = idx_ff;
      q_in         = q_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      unique case (op)
         UOP_START: begin
            if (req_ff.price_cents == 16'd0 || !req_ff.in_stock) begin
               active_in = 1'b0;
               status_in = ST_BAD_ITEM;
            end else begin
               active_in  = 1'b1;
               price_in   = req_ff.price_cents;
               paid_in    = '0;
               working_in = committed_ff;
               status_in  = ST_ACCEPTED;
            end
         end
         UOP_COIN: begin
            if (!active_ff) begin
               status_in = ST_IDLE;
            end else if (!hit.ok) begin
               status_in = ST_BAD_COIN;
            end else begin
               if (rd_cnt != CNT_MAX) begin
                  working_in[hit.idx] = rd_cnt + COUNT_BITS'(1);
               end
               paid_in = paid_next;
               if (paid_next < {1'b0, price_ff}) begin
                  status_in = ST_ACCEPTED;
               end else begin
                  left_in   = 10'(paid_next - {1'b0, price_ff});
                  change_in = 10'(paid_next - {1'b0, price_ff});
                  idx_in    = '0;
                  for (int i = 0; i < NUM_DENOMS; i++) begin
                     given_in[i] = '0;
                  end
               end
            end
         end
         UOP_DIV: begin
            q_in = recip_prod[23:16];
         end
         UOP_TAKE: begin
            working_in[idx_ff] = rd_cnt - COUNT_BITS'(take);
            given_in[idx_ff]   = take;
            left_in            = short ? (left_ff - cd_prod[9:0]) : rem_fix;
            idx_in             = idx_ff + 3'd1;
         end
         UOP_SETTLE: begin
            active_in = 1'b0;
            if (left_ff == 10'd0) begin
               committed_in = working_ff;
               status_in    = ST_DISPENSED;
            end else begin
               status_in    = ST_NO_CHANGE;
            end
         end
         UOP_CANCEL: begin
            if (active_ff) begin
               active_in = 1'b0;
               status_in = ST_CANCELLED;
            end else begin
               status_in = ST_IDLE;
            end
         end
         UOP_FILL: begin
            active_in = 1'b0;
            for (int i = 0; i < NUM_DENOMS; i++) begin
               committed_in[i] = COUNT_BITS'(default_ff);
            end
            status_in = ST_ADMIN;
         end
         UOP_LOAD: begin
            active_in = 1'b0;
            committed_in[req_ff.denom_index] = COUNT_BITS'(req_ff.count_value);
            status_in = ST_ADMIN;
         end
         UOP_READ: begin
            status_in = ST_ADMIN;
         end
         UOP_UNUSED: begin
            status_in = ST_IDLE;
         end
         UOP_RESP: begin
            rsp_valid_in        = 1'b1;
            rsp_in.status       = status_ff;
            rsp_in.dispense     = (status_ff == ST_DISPENSED);
            rsp_in.amount_due   = (active_ff && paid_ff < {1'b0, price_ff}) ?
                                  16'({1'b0, price_ff} - paid_ff) : 16'd0;
            rsp_in.change_cents = (status_ff == ST_DISPENSED) ? change_ff : 10'd0;
            rsp_in.count_ten_dollar  = out_cnt[0];
            rsp_in.count_five_dollar = out_cnt[1];
            rsp_in.count_two_dollar  = out_cnt[2];
            rsp_in.count_one_dollar  = out_cnt[3];
            rsp_in.count_fifty_cent  = out_cnt[4];
            rsp_in.count_twenty_cent = out_cnt[5];
            rsp_in.count_ten_cent    = out_cnt[6];
            rsp_in.count_five_cent   = out_cnt[7];
         end
         default: begin
         end
      endcase
   end

   // counts shown in the result: change given, stored counts, or zero
   always_comb begin
      for (int i = 0; i < NUM_DENOMS; i++) begin
         if (status_ff == ST_DISPENSED) begin
            out_cnt[i] = {8'd0, given_ff[i]};
         end else if (req_ff.command == CMD_READ) begin
            out_cnt[i] = low16(committed_ff[i]);
         end else begin
            out_cnt[i] = 16'd0;
         end
      end
   end

   // control state and coin store
   always_ff @(posedge clock) begin
      if (reset) begin
         default_ff   <= 16'd20;
         active_ff    <= 1'b0;
         price_ff     <= '0;
         paid_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_DENOMS; i++) begin
            committed_ff[i] <= '0;
            working_ff[i]   <= '0;
         end
      end else begin
         default_ff   <= default_in;
         active_ff    <= active_in;
         price_ff     <= price_in;
         paid_ff      <= paid_in;
         rsp_valid_ff <= rsp_valid_in;
         committed_ff <= committed_in;
         working_ff   <= working_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (go) begin
         req_ff <= req_item;
      end
      given_ff  <= given_in;
      left_ff   <= left_in;
      change_ff <= change_in;
      idx_ff    <= idx_in;
      q_ff      <= q_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

### design/coin_changer_transaction.sv
// coin_changer_transaction: top level of the coin changer
// depends on coinchg_pkg, coinchg_useq and coinchg_dpath
//
// Usage
//   Input channel: drive req_item and raise start; the item is taken at the
//   rising edge where start is high and busy is low. busy stays high while
//   the item's microcode routine runs.
//   Result channel: rsp_valid is high for exactly one cycle with rsp_item;
//   the receiver cannot stall, so it must take the item in that cycle.
//   Config channel: csr_data is written to the default coin count at an edge
//   with csr_valid and csr_ready high; csr_ready is always high. Write it
//   only while no item is in flight.
// Sequence
//   Start, cancel, admin and unused commands and a coin that leaves money due
//   or is refused run an operation step, then a result step; the result strobe
//   follows in the next cycle, where a new item may already be taken.
//   A coin that completes the payment runs the coin step, then the greedy
//   change pass (quotient estimate step, then correct-and-take step, for each
//   of the eight denominations), then the settle and result steps.
// Reset
//   Synchronous: no session open, all coin counts zero, default count 20.
`default_nettype none

module coin_changer_transaction #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire coinchg_pkg::req_type req_item,
   output logic                      rsp_valid,
   output coinchg_pkg::rsp_type      rsp_item,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [15:0]          csr_data
);
   import coinchg_pkg::*;

   logic      go;
   uop_type   op;
   flags_type flags;

   // item handshake and config write
   assign go        = start && !busy;
   assign csr_ready = 1'b1;

   // control sequencer
   coinchg_useq u_useq (
      .clock   (clock),
      .reset   (reset),
      .go      (go),
      .command (req_item.command),
      .flags   (flags),
      .op      (op),
      .busy    (busy)
   );

   // datapath
   coinchg_dpath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .req_item  (req_item),
      .op        (op),
      .csr_we    (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .flags     (flags),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

### design/coinchg_checker.sv
// coinchg_checker: port-level checks on the coin changer top level
// depends on coinchg_pkg; bound to coin_changer_transaction below
`default_nettype none

module coinchg_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 start,
   input wire logic                 busy,
   input wire logic                 rsp_valid,
   input wire coinchg_pkg::rsp_type rsp_item
);
   import coinchg_pkg::*;

   // an accepted item always occupies the block
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("item accepted but block not busy");

   // a result never shows while an item is still running
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // the end of every routine shows a result strobe in the cycle where busy falls
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("routine ended without a result");

   // dispense goes with the dispensed status only
   a_dispense: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.dispense == (rsp_item.status == ST_DISPENSED)))
      else $error("dispense flag disagrees with status");

   // change is only reported on dispense
   a_change: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status != ST_DISPENSED |-> rsp_item.change_cents == 10'd0)
      else $error("change reported without dispense");

endmodule

bind coin_changer_transaction coinchg_checker u_coinchg_checker (.*);

`default_nettype wire

### dv/coin_changer_txn_check.sv
`timescale 1ns / 1ps
// coin_changer_txn_check: watches the item, result and csr channels of the coin changer
// keeps its own coin store and session, predicts every result; depends on coinchg_pkg
module coin_changer_txn_check
   import coinchg_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic    busy,
   input  wire req_type req_item,
   input  wire logic    rsp_valid,
   input  wire rsp_type rsp_item,
   input  wire logic    csr_valid,
   input  wire logic    csr_ready,
   input  wire logic    [15:0] csr_data,
   output int           error_count,
   output int           pending_count
);

   localparam int               CNT_W   = 16;
   localparam logic [CNT_W-1:0] CNT_SAT = '1;
   localparam int               REPORT_LIMIT = 10;

   // predicted machine state
   logic [15:0]      fill_count;
   logic             in_session;
   logic [15:0]      price_held;
   logic [16:0]      paid_sum;
   logic [CNT_W-1:0] store_committed [NUM_DENOMS];
   logic [CNT_W-1:0] store_working [NUM_DENOMS];

   rsp_type awaited_replies [$];
   rsp_type oldest_reply;
   int      mismatches;

   // coin value in cents, largest first
   function automatic int coin_value(input int i);
      case (i)
         0:       return 1000;
         1:       return 500;
         2:       return 200;
         3:       return 100;
         4:       return 50;
         5:       return 20;
         6:       return 10;
         default: return 5;
      endcase
   endfunction

   // denomination slot of an inserted value, -1 when it is no coin
   function automatic int coin_index(input logic [15:0] cents);
      for (int i = 0; i < NUM_DENOMS; i++) begin
         if (int'(cents) == coin_value(i)) return i;
      end
      return -1;
   endfunction

   // apply one item to the predicted state and return its result
   function automatic rsp_type run_command(input req_type r);
      rsp_type                    o;
      logic [NUM_DENOMS-1:0][15:0] given;
      int                         idx;
      int                         change;
      int                         left;
      int                         want;
      int                         take;
      o = '0;
      given = '0;
      o.status = ST_IDLE;
      case (r.command)
         CMD_START: begin
            if (r.price_cents == 16'd0 || !r.in_stock) begin
               in_session = 1'b0;
               o.status = ST_BAD_ITEM;
            end else begin
               in_session = 1'b1;
               price_held = r.price_cents;
               paid_sum = '0;
               for (int i = 0; i < NUM_DENOMS; i++) store_working[i] = store_committed[i];
               o.status = ST_ACCEPTED;
            end
         end
         CMD_INSERT: begin
            if (in_session) begin
               idx = coin_index(r.coin_cents);
               if (idx < 0) begin
                  o.status = ST_BAD_COIN;
               end else begin
                  if (store_working[idx] != CNT_SAT) store_working[idx]++;
                  paid_sum = paid_sum + 17'(coin_value(idx));
                  if (paid_sum < {1'b0, price_held}) begin
                     o.status = ST_ACCEPTED;
                  end else begin
                     // greedy change from the largest coin down, bounded by coins held
                     change = int'(paid_sum) - int'(price_held);
                     left = change;
                     for (int i = 0; i < NUM_DENOMS; i++) begin
                        want = left / coin_value(i);
                        take = (want < int'(store_working[i])) ? want : int'(store_working[i]);
                        given[i] = 16'(take);
                        store_working[i] = store_working[i] - CNT_W'(take);
                        left = left - take * coin_value(i);
                     end
                     in_session = 1'b0;
                     if (left != 0) begin
                        o.status = ST_NO_CHANGE;
                        given = '0;
                     end else begin
                        for (int i = 0; i < NUM_DENOMS; i++)
                           store_committed[i] = store_working[i];
                        o.status = ST_DISPENSED;
                        o.dispense = 1'b1;
                        o.change_cents = 10'(change);
                     end
                  end
               end
            end
         end
         CMD_CANCEL: begin
            if (in_session) begin
               in_session = 1'b0;
               o.status = ST_CANCELLED;
            end
         end
         CMD_FILL: begin
            in_session = 1'b0;
            for (int i = 0; i < NUM_DENOMS; i++) store_committed[i] = CNT_W'(fill_count);
            o.status = ST_ADMIN;
         end
         CMD_LOAD: begin
            in_session = 1'b0;
            store_committed[r.denom_index] = CNT_W'(r.count_value);
            o.status = ST_ADMIN;
         end
         CMD_READ: begin
            for (int i = 0; i < NUM_DENOMS; i++) given[i] = 16'(store_committed[i]);
            o.status = ST_ADMIN;
         end
         default: o.status = ST_IDLE;
      endcase
      o.amount_due = (in_session && paid_sum < {1'b0, price_held}) ?
                     16'({1'b0, price_held} - paid_sum) : 16'd0;
      o.count_ten_dollar  = given[0];
      o.count_five_dollar = given[1];
      o.count_two_dollar  = given[2];
      o.count_one_dollar  = given[3];
      o.count_fifty_cent  = given[4];
      o.count_twenty_cent = given[5];
      o.count_ten_cent    = given[6];
      o.count_five_cent   = given[7];
      return o;
   endfunction

   function automatic bit replies_match(input rsp_type a, input rsp_type b);
      return a.status === b.status && a.dispense === b.dispense &&
             a.amount_due === b.amount_due && a.change_cents === b.change_cents &&
             a.count_ten_dollar === b.count_ten_dollar &&
             a.count_five_dollar === b.count_five_dollar &&
             a.count_two_dollar === b.count_two_dollar &&
             a.count_one_dollar === b.count_one_dollar &&
             a.count_fifty_cent === b.count_fifty_cent &&
             a.count_twenty_cent === b.count_twenty_cent &&
             a.count_ten_cent === b.count_ten_cent &&
             a.count_five_cent === b.count_five_cent;
   endfunction

   function automatic string show_reply(input rsp_type r);
      return $sformatf({"status=%0d dispense=%0b due=%0d change=%0d ",
                        "coins=%0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d"},
                       r.status, r.dispense, r.amount_due, r.change_cents,
                       r.count_ten_dollar, r.count_five_dollar, r.count_two_dollar,
                       r.count_one_dollar, r.count_fifty_cent, r.count_twenty_cent,
                       r.count_ten_cent, r.count_five_cent);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         fill_count = 16'd20;
         in_session = 1'b0;
         price_held = '0;
         paid_sum = '0;
         for (int i = 0; i < NUM_DENOMS; i++) begin
            store_committed[i] = '0;
            store_working[i] = '0;
         end
         awaited_replies.delete();
         mismatches = 0;
      end else begin
         // compare a result against the oldest prediction
         if (rsp_valid) begin
            if (awaited_replies.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected result item: %s", show_reply(rsp_item));
            end else begin
               oldest_reply = awaited_replies.pop_front();
               if (!replies_match(oldest_reply, rsp_item)) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("result mismatch at %0t", $realtime);
                     $display("  expected %s", show_reply(oldest_reply));
                     $display("  actual   %s", show_reply(rsp_item));
                  end
               end
            end
         end
         // default count register write
         if (csr_valid && csr_ready) fill_count = csr_data;
         // accepted input item, queued behind the earlier predictions
         if (start && !busy) awaited_replies = {awaited_replies, run_command(req_item)};
      end
      error_count   <= mismatches;
      pending_count <= awaited_replies.size();
   end

endmodule

### dv/coin_changer_transaction_tb.sv
`timescale 1ns / 1ps
// coin_changer_transaction_tb: directed and random purchase sessions, admin commands and
// default count writes; depends on coinchg_pkg, coin_changer_transaction, coin_changer_txn_check
module coin_changer_transaction_tb;
   import coinchg_pkg::*;

   // command codes the block treats as unused
   localparam logic [2:0] CMD_SPARE_LO = 3'd6;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int ITEM_GOAL    = 1950;
   localparam int NUM_PHASES   = 6;
   localparam int SETTLE_WAIT  = 30;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_item;
   logic        rsp_valid;
   rsp_type     rsp_item;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;

   int error_count;
   int pending_count;
   int cycle_count = 0;
   int items_sent = 0;
   int sender_idle_pct = 0;

   coin_changer_transaction #(.COUNT_BITS(16)) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   coin_changer_txn_check watch (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_item      (rsp_item),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic logic [15:0] coin_at(input int i);
      case (i)
         0:       return 16'd1000;
         1:       return 16'd500;
         2:       return 16'd200;
         3:       return 16'd100;
         4:       return 16'd50;
         5:       return 16'd20;
         6:       return 16'd10;
         default: return 16'd5;
      endcase
   endfunction

   function automatic req_type make_item(input logic [2:0] cmd, input logic [15:0] price,
                                         input logic stock, input logic [15:0] coin,
                                         input logic [2:0] didx, input logic [15:0] cval);
      req_type r;
      r.command     = cmd;
      r.price_cents = price;
      r.in_stock    = stock;
      r.coin_cents  = coin;
      r.denom_index = didx;
      r.count_value = cval;
      return r;
   endfunction

   // same command with random values in the fields it does not use
   function automatic req_type loose_item(input logic [2:0] cmd);
      return make_item(cmd, 16'($urandom), 1'($urandom), 16'($urandom),
                       3'($urandom), 16'($urandom));
   endfunction

   // mostly multiples of 5, some tiny and some arbitrary prices
   function automatic logic [15:0] pick_price();
      case ($urandom_range(0, 9))
         0:       return 16'($urandom);
         1:       return 16'($urandom_range(1, 12));
         default: return 16'(5 * $urandom_range(1, 400));
      endcase
   endfunction

   // a value that matches no denomination
   function automatic logic [15:0] pick_bad_coin();
      logic [15:0] v;
      v = 16'($urandom);
      if (v <= 16'd1000 && v % 5 == 0) v = v + 16'd1;
      return v;
   endfunction

   // present one item, with random sender idling ahead of it
   task automatic send_item(input req_type r);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   task automatic send(input logic [2:0] cmd, input logic [15:0] price, input logic stock,
                       input logic [15:0] coin, input logic [2:0] didx,
                       input logic [15:0] cval);
      send_item(make_item(cmd, price, stock, coin, didx, cval));
   endtask

   // hold the sender until every result is back and the block has gone quiet
   task automatic wait_settled();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_fill_count(input logic [15:0] value);
      wait_settled();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // one purchase: start, then coins until paid, with bad coins, reads,
   // cancels and abandoned sessions mixed in
   task automatic run_session();
      logic [15:0] price;
      logic [15:0] coin;
      int          paid;
      int          pick;
      price = pick_price();
      send_item(make_item(CMD_START, price, 1'b1, 16'($urandom), 3'($urandom),
                          16'($urandom)));
      paid = 0;
      while (paid < int'(price)) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            send_item(make_item(CMD_INSERT, 16'($urandom), 1'($urandom), pick_bad_coin(),
                                3'($urandom), 16'($urandom)));
         end else if (pick < 8) begin
            send_item(loose_item(CMD_CANCEL));
            return;
         end else if (pick < 9) begin
            send_item(loose_item(CMD_READ));
         end else if (pick < 10) begin
            return;
         end else begin
            if (int'(price) - paid > 2000 && $urandom_range(0, 3) != 0)
               coin = coin_at(0);
            else
               coin = coin_at($urandom_range(0, 7));
            send_item(make_item(CMD_INSERT, 16'($urandom), 1'($urandom), coin,
                                3'($urandom), 16'($urandom)));
            paid = paid + int'(coin);
         end
      end
   endtask

   function automatic logic [15:0] pick_load_count();
      case ($urandom_range(0, 7))
         0:       return 16'hFFFF;
         1:       return 16'($urandom);
         2:       return 16'd0;
         default: return 16'($urandom_range(0, 30));
      endcase
   endfunction

   initial begin
      int          phase_goal;
      int          pick;
      logic [15:0] fill_value;

      reset     <= 1'b1;
      start     <= 1'b0;
      req_item  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed items, coin store empty after reset
      sender_idle_pct = 25;
      send(CMD_READ, 16'd0, 1'b0, 16'd0, 3'd0, 16'd0);
      send(CMD_INSERT, 16'd0, 1'b0, 16'd100, 3'd0, 16'd0);
      send(CMD_CANCEL, 16'd0, 1'b0, 16'd0, 3'd0, 16'd0);
      send(CMD_SPARE_LO, 16'hFFFF, 1'b1, 16'hFFFF, 3'd7, 16'hFFFF);
      send(CMD_SPARE_HI, 16'd0, 1'b0, 16'd0, 3'd0, 16'd0);
      // bad item: zero price, then out of stock
      send(CMD_START, 16'd0, 1'b1, 16'd0, 3'd0, 16'd0);
      send(CMD_START, 16'd100, 1'b0, 16'd0, 3'd0, 16'd0);
      // restart over an open session
      send(CMD_START, 16'd100, 1'b1, 16'd0, 3'd0, 16'd0);
      send(CMD_INSERT, 16'd0, 1'b0, 16'd5, 3'd0, 16'd0);
      send(CMD_START, 16'd135, 1'b1, 16'd0, 3'd0, 16'd0);
      // bad coins keep the session open
      send(CMD_INSERT, 16'd0, 1'b0, 16'd7, 3'd0, 16'd0);
      send(CMD_INSERT, 16'd0, 1'b0, 16'hFFFF, 3'd0, 16'd0);
      // no change from an empty store
      send(CMD_INSERT, 16'd0, 1'b0, 16'd1000, 3'd0, 16'd0);
      send(CMD_FILL, 16'd0, 1'b0, 16'd0, 3'd0, 16'd0);
      // read mid-session, then exact change paid out
      send(CMD_START, 16'd135, 1'b1, 16'd0, 3'd0, 16'd0);
      send(CMD_INSERT, 16'd0, 1'b0, 16'd100, 3'd0, 16'd0);
      send(CMD_READ, 16'd0, 1'b0, 16'd0, 3'd0, 16'd0);
      send(CMD_INSERT, 16'd0, 1'b0, 16'd50, 3'd0, 16'd0);
      // price not a multiple of 5
      send(CMD_START, 16'd3, 1'b1, 16'd0, 3'd0, 16'd0);
      send(CMD_INSERT, 16'd0, 1'b0, 16'd5, 3'd0, 16'd0);
      // largest price, then cancel
      send(CMD_START, 16'hFFFF, 1'b1, 16'd0, 3'd0, 16'd0);
      send(CMD_INSERT, 16'd0, 1'b0, 16'd1000, 3'd0, 16'd0);
      send(CMD_CANCEL, 16'd0, 1'b0, 16'd0, 3'd0, 16'd0);
      // saturated 5-cent count
      send(CMD_LOAD, 16'd0, 1'b0, 16'd0, 3'd7, 16'hFFFF);
      send(CMD_START, 16'd5, 1'b1, 16'd0, 3'd0, 16'd0);
      send(CMD_INSERT, 16'd0, 1'b0, 16'd5, 3'd0, 16'd0);
      // load during a session closes it
      send(CMD_START, 16'd300, 1'b1, 16'd0, 3'd0, 16'd0);
      send(CMD_LOAD, 16'd0, 1'b0, 16'd0, 3'd0, 16'd0);
      send(CMD_INSERT, 16'd0, 1'b0, 16'd100, 3'd0, 16'd0);

      // random phases, each with its own default count
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0:       fill_value = 16'd0;
            1:       fill_value = 16'hFFFF;
            2:       fill_value = 16'd3;
            3:       fill_value = 16'($urandom);
            4:       fill_value = 16'd1;
            default: fill_value = 16'd20;
         endcase
         write_fill_count(fill_value);
         sender_idle_pct = (p < 2) ? 25 : (p < 4) ? 49 : 0;
         send_item(loose_item(CMD_FILL));
         phase_goal = items_sent + ITEM_GOAL / NUM_PHASES;
         while (items_sent < phase_goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               run_session();
            end else if (pick < 75) begin
               send_item(loose_item(CMD_FILL));
            end else if (pick < 82) begin
               send_item(make_item(CMD_LOAD, 16'($urandom), 1'($urandom), 16'($urandom),
                                   3'($urandom), pick_load_count()));
            end else if (pick < 85) begin
               send_item(loose_item(CMD_READ));
            end else begin
               send_item(loose_item(3'($urandom)));
            end
         end
      end

      wait_settled();
      if (error_count == 0 && pending_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
